// File: hdl/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types and constants of the multilevel feedback queue scheduler:
// transaction payloads, operation and status codes, register map.
// ----------------------------------------------------------------------------
`default_nettype none

package mlfq_pkg;

  // default sizes of the scheduler
  localparam int unsigned MaxLevelsDef = 8;
  localparam int unsigned MaxProcsDef  = 32;

  // process id width, fixed by the payload fields
  localparam int unsigned IdW = 8;

  // register reset values
  localparam logic [3:0]  NumLevelsRst = 4'd3;
  localparam logic [15:0] QuantumRst   = 16'd8;

  // operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_ADMIT   = 2'd0,
    OP_SLICE   = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  // status codes of a result transaction
  typedef enum logic [3:0] {
    ST_STAYED       = 4'd0,
    ST_DEMOTED      = 4'd1,
    ST_ENDED        = 4'd2,
    ST_BOOSTED      = 4'd3,
    ST_QUANTUM_OUT  = 4'd4,
    ST_EMPTY        = 4'd5,
    ST_ADMITTED     = 4'd6,
    ST_REJECTED     = 4'd7,
    ST_RESTART_DONE = 4'd8
  } status_e;

  // register indexes on the configuration port
  typedef enum logic [0:0] {
    REG_NUM_LEVELS = 1'b0,
    REG_QUANTUM    = 1'b1
  } reg_idx_e;

  // input transaction
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] proc_id;
    logic       demote;
    logic       final_instr;
  } sched_in_t;

  // result transaction
  typedef struct packed {
    logic [3:0] status;
    logic [7:0] proc_id_out;
    logic [3:0] level;
    logic       last;
  } sched_out_t;

  // pointer table command for the selected level
  typedef struct packed {
    logic pop;
    logic push;
    logic clear;
  } qtab_cmd_t;

endpackage

`default_nettype wire

// File: hdl/mlfq_store.sv
// ----------------------------------------------------------------------------
// mlfq_store
// Queue entry memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfq_store #(
  parameter int unsigned DATA_W = 12,
  parameter int unsigned ADDR_W = 9
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/mlfq_qtab.sv
// ----------------------------------------------------------------------------
// mlfq_qtab
// Per-level head, tail and occupancy table. One level is selected at a time
// for read and update; non-empty flags of all levels feed the level search.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfq_qtab #(
  parameter int unsigned MAX_LEVELS = 8,
  parameter int unsigned MAX_PROCS  = 32,
  localparam int unsigned LIW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1,
  localparam int unsigned PW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1,
  localparam int unsigned CW  = $clog2(MAX_PROCS + 1)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [LIW-1:0]             sel_i,
  input  wire mlfq_pkg::qtab_cmd_t        cmd_i,
  output logic      [PW-1:0]              head_o,
  output logic      [PW-1:0]              tail_o,
  output logic      [CW-1:0]              cnt_o,
  output logic      [MAX_LEVELS-1:0]      nonempty_o
);

  import mlfq_pkg::*;

  localparam logic [PW-1:0] LastSlot = PW'(MAX_PROCS - 1);

  logic [PW-1:0] head_q [MAX_LEVELS];
  logic [PW-1:0] tail_q [MAX_LEVELS];
  logic [CW-1:0] cnt_q  [MAX_LEVELS];

  // selected level
  assign head_o = head_q[sel_i];
  assign tail_o = tail_q[sel_i];
  assign cnt_o  = cnt_q[sel_i];

  // occupancy flags for the priority search
  always_comb begin
    for (int k = 0; k < MAX_LEVELS; k++) begin
      nonempty_o[k] = (cnt_q[k] != '0);
    end
  end

  // pointer and count update of the selected level, wrapping at the depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_LEVELS; k++) begin
        head_q[k] <= '0;
        tail_q[k] <= '0;
        cnt_q[k]  <= '0;
      end
    end else begin
      for (int k = 0; k < MAX_LEVELS; k++) begin
        if (LIW'(k) == sel_i) begin
          if (cmd_i.clear) begin
            head_q[k] <= '0;
            tail_q[k] <= '0;
          end else begin
            if (cmd_i.pop) begin
              head_q[k] <= (head_q[k] == LastSlot) ? '0 : head_q[k] + 1'b1;
            end
            if (cmd_i.push) begin
              tail_q[k] <= (tail_q[k] == LastSlot) ? '0 : tail_q[k] + 1'b1;
            end
            if (cmd_i.pop && !cmd_i.push) begin
              cnt_q[k] <= cnt_q[k] - 1'b1;
            end else if (cmd_i.push && !cmd_i.pop) begin
              cnt_q[k] <= cnt_q[k] + 1'b1;
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/mlfq_regs.sv
// ----------------------------------------------------------------------------
// mlfq_regs
// Configuration registers behind an APB-style port: level count and
// quantum slice limit. Always ready, reads return the stored value.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfq_regs (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [3:0]  num_levels_o,
  output logic      [15:0] quantum_o
);

  import mlfq_pkg::*;

  logic       wr_en;
  reg_idx_e   reg_idx;
  logic [3:0]  num_levels_q;
  logic [15:0] quantum_q;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[2]);

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_levels_q <= NumLevelsRst;
      quantum_q    <= QuantumRst;
    end else if (wr_en) begin
      case (reg_idx)
        REG_NUM_LEVELS: num_levels_q <= pwdata[3:0];
        REG_QUANTUM:    quantum_q    <= pwdata[15:0];
        default:        ;
      endcase
    end
  end

  // register read
  always_comb begin
    case (reg_idx)
      REG_NUM_LEVELS: prdata = {28'd0, num_levels_q};
      REG_QUANTUM:    prdata = {16'd0, quantum_q};
      default:        prdata = '0;
    endcase
  end

  assign num_levels_o = num_levels_q;
  assign quantum_o    = quantum_q;

endmodule

`default_nettype wire

// File: hdl/multilevel_feedback_queue_scheduler_top.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler_top
// Multilevel feedback queue scheduler with priority boost.
//
// Input channel (in_valid_i / in_stall_o) carries one command: admit, run
// one slice, or restart the quantum. Output channel (out_valid_o /
// out_stall_i) returns results; the last result of a command has last set.
// The APB-style port holds the level count and the quantum slice limit.
//
// Commands run one at a time. An admit result, and a quantum-out or empty
// slice result, is loaded into the output register from S_EXEC; a slice
// that runs a process reads the head in S_EXEC and writes it back in S_SLICE.
// The next command is taken only once the sequencer is back in S_IDLE.
// Restart gathers every live process into a scratch row of the entry
// memory, then rewrites them into the top level. The entry memory has a
// single read and a single write port.
// A result waits in the output register while the receiver stalls; the
// sequencer holds at the next result until it can be loaded, and a new
// command is still taken while the last result waits.
// Reset empties all levels, clears the slice count and loads the register
// defaults (3 levels, 8 slices). Entry memory needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module multilevel_feedback_queue_scheduler_top #(
  parameter int unsigned MAX_LEVELS = mlfq_pkg::MaxLevelsDef,
  parameter int unsigned MAX_PROCS  = mlfq_pkg::MaxProcsDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire mlfq_pkg::sched_in_t    in_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output mlfq_pkg::sched_out_t        out_data_o,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [2:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic      [31:0]            prdata,
  output logic                        pready
);

  import mlfq_pkg::*;

  localparam int unsigned LIW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned LVW    = $clog2(MAX_LEVELS + 1);
  localparam int unsigned PW     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CW     = $clog2(MAX_PROCS + 1);
  localparam int unsigned RW     = $clog2(MAX_LEVELS + 1);
  localparam int unsigned ADDR_W = RW + PW;
  localparam int unsigned DATA_W = IdW + LVW;

  localparam logic [RW-1:0]  ScratchRow = RW'(MAX_LEVELS);
  localparam logic [LVW-1:0] MaxLvl     = LVW'(MAX_LEVELS);
  localparam logic [LIW-1:0] TopRowMax  = LIW'(MAX_LEVELS - 1);
  localparam logic [CW-1:0]  ProcLimit  = CW'(MAX_PROCS);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_EXEC     = 8'b0000_0010,
    S_SLICE    = 8'b0000_0100,
    S_GATH     = 8'b0000_1000,
    S_GATH_WR  = 8'b0001_0000,
    S_BOOST_RD = 8'b0010_0000,
    S_BOOST_WR = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  sched_in_t item_q;
  logic [LIW-1:0] slice_row_q, slice_row_d;
  logic [LIW-1:0] lvl_q, lvl_d;
  logic [CW-1:0]  n_q, n_d;
  logic [CW-1:0]  i_q, i_d;
  logic [CW-1:0]  total_q, total_d;
  logic [15:0]    slices_q, slices_d;

  logic       out_valid_q;
  sched_out_t out_data_q;
  logic       out_free;
  logic       emit;
  sched_out_t emit_data;

  logic [3:0]  num_levels;
  logic [15:0] quantum;
  logic [4:0]  num_ext;
  logic [LVW-1:0] eff_lvl;
  logic [LIW-1:0] top_row;

  logic [LIW-1:0]        qsel;
  qtab_cmd_t             qcmd;
  logic [PW-1:0]         q_head;
  logic [PW-1:0]         q_tail;
  logic [CW-1:0]         q_cnt;
  logic [MAX_LEVELS-1:0] q_nonempty;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  logic [IdW-1:0]    rd_id;
  logic [LVW-1:0]    rd_lvl;

  logic           found;
  logic [LIW-1:0] found_row;
  logic [LIW-1:0] tgt_row;
  logic           boosted;

  // configuration registers
  mlfq_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .num_levels_o (num_levels),
    .quantum_o    (quantum)
  );

  // per-level pointers and counts
  mlfq_qtab #(
    .MAX_LEVELS (MAX_LEVELS),
    .MAX_PROCS  (MAX_PROCS)
  ) u_qtab (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sel_i      (qsel),
    .cmd_i      (qcmd),
    .head_o     (q_head),
    .tail_o     (q_tail),
    .cnt_o      (q_cnt),
    .nonempty_o (q_nonempty)
  );

  // queue entries; one row per level plus a scratch row for restart
  mlfq_store #(
    .DATA_W (DATA_W),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd_id  = mem_rdata[DATA_W-1 -: IdW];
  assign rd_lvl = mem_rdata[LVW-1:0];

  // effective level count, clamped to 1..MAX_LEVELS
  assign num_ext = {1'b0, num_levels};
  always_comb begin
    if (num_levels == 4'd0) begin
      eff_lvl = LVW'(1);
    end else if (num_ext > 5'(MAX_LEVELS)) begin
      eff_lvl = MaxLvl;
    end else begin
      eff_lvl = LVW'(num_levels);
    end
  end
  assign top_row = LIW'(eff_lvl - LVW'(1));

  // highest non-empty level within the effective range
  always_comb begin
    found     = 1'b0;
    found_row = '0;
    for (int r = 0; r < MAX_LEVELS; r++) begin
      if (q_nonempty[r] && (LVW'(r) < eff_lvl)) begin
        found     = 1'b1;
        found_row = LIW'(r);
      end
    end
  end

  // slice target: same level, one down, or kept at the bottom
  assign tgt_row = (item_q.demote && (slice_row_q != '0)) ? slice_row_q - 1'b1 : slice_row_q;
  assign boosted = (rd_lvl != eff_lvl);

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // sequencer
  always_comb begin
    state_d     = state_q;
    slice_row_d = slice_row_q;
    lvl_d       = lvl_q;
    n_d         = n_q;
    i_d         = i_q;
    total_d     = total_q;
    slices_d    = slices_q;
    qsel        = top_row;
    qcmd        = '0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    emit        = 1'b0;
    emit_data   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        case (item_q.op)
          OP_ADMIT: begin
            qsel = top_row;
            if (out_free) begin
              emit                  = 1'b1;
              emit_data.proc_id_out = item_q.proc_id;
              emit_data.last        = 1'b1;
              if (total_q >= ProcLimit) begin
                emit_data.status = ST_REJECTED;
              end else begin
                mem_we           = 1'b1;
                mem_waddr        = {RW'(top_row), q_tail};
                mem_wdata        = {item_q.proc_id, eff_lvl};
                qcmd.push        = 1'b1;
                total_d          = total_q + 1'b1;
                emit_data.status = ST_ADMITTED;
                emit_data.level  = 4'(eff_lvl);
              end
              state_d = S_IDLE;
            end
          end

          OP_SLICE: begin
            if ((slices_q >= quantum) || !found) begin
              if (out_free) begin
                emit             = 1'b1;
                emit_data.status = (slices_q >= quantum) ? ST_QUANTUM_OUT : ST_EMPTY;
                emit_data.last   = 1'b1;
                state_d          = S_IDLE;
              end
            end else begin
              // pop the head; the id arrives next cycle
              qsel        = found_row;
              qcmd.pop    = 1'b1;
              mem_re      = 1'b1;
              mem_raddr   = {RW'(found_row), q_head};
              slices_d    = slices_q + 16'd1;
              slice_row_d = found_row;
              state_d     = S_SLICE;
            end
          end

          OP_RESTART: begin
            lvl_d   = TopRowMax;
            n_d     = '0;
            state_d = S_GATH;
          end

          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_SLICE: begin
        qsel = tgt_row;
        if (out_free) begin
          emit                  = 1'b1;
          emit_data.proc_id_out = rd_id;
          emit_data.last        = 1'b1;
          if (item_q.final_instr) begin
            total_d          = total_q - 1'b1;
            emit_data.status = ST_ENDED;
          end else begin
            mem_we           = 1'b1;
            mem_waddr        = {RW'(tgt_row), q_tail};
            mem_wdata        = {rd_id, LVW'(tgt_row) + LVW'(1)};
            qcmd.push        = 1'b1;
            emit_data.status = item_q.demote ? ST_DEMOTED : ST_STAYED;
            emit_data.level  = 4'(LVW'(tgt_row) + LVW'(1));
          end
          state_d = S_IDLE;
        end
      end

      // drain every level, top first, into the scratch row
      S_GATH: begin
        qsel = lvl_q;
        if (q_cnt != '0) begin
          qcmd.pop  = 1'b1;
          mem_re    = 1'b1;
          mem_raddr = {RW'(lvl_q), q_head};
          state_d   = S_GATH_WR;
        end else begin
          qcmd.clear = 1'b1;
          if (lvl_q == '0) begin
            i_d     = '0;
            total_d = n_q;
            state_d = S_BOOST_RD;
          end else begin
            lvl_d = lvl_q - 1'b1;
          end
        end
      end

      S_GATH_WR: begin
        qsel      = lvl_q;
        mem_we    = 1'b1;
        mem_waddr = {ScratchRow, n_q[PW-1:0]};
        mem_wdata = {rd_id, LVW'(lvl_q) + LVW'(1)};
        n_d       = n_q + 1'b1;
        state_d   = S_GATH;
      end

      // refill the top level from the scratch row in order
      S_BOOST_RD: begin
        if (i_q == n_q) begin
          state_d = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = {ScratchRow, i_q[PW-1:0]};
          state_d   = S_BOOST_WR;
        end
      end

      S_BOOST_WR: begin
        qsel = top_row;
        if (!boosted || out_free) begin
          mem_we    = 1'b1;
          mem_waddr = {RW'(top_row), q_tail};
          mem_wdata = {rd_id, eff_lvl};
          qcmd.push = 1'b1;
          i_d       = i_q + 1'b1;
          if (boosted) begin
            emit                  = 1'b1;
            emit_data.status      = ST_BOOSTED;
            emit_data.proc_id_out = rd_id;
            emit_data.level       = 4'(eff_lvl);
          end
          state_d = S_BOOST_RD;
        end
      end

      S_DONE: begin
        if (out_free) begin
          emit             = 1'b1;
          emit_data.status = ST_RESTART_DONE;
          emit_data.last   = 1'b1;
          slices_d         = '0;
          state_d          = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slice_row_q <= '0;
      lvl_q       <= '0;
      n_q         <= '0;
      i_q         <= '0;
      total_q     <= '0;
      slices_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slice_row_q <= slice_row_d;
      lvl_q       <= lvl_d;
      n_q         <= n_d;
      i_q         <= i_d;
      total_q     <= total_d;
      slices_q    <= slices_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // captured command and result payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_data_i;
    end
    if (emit) begin
      out_data_q <= emit_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a command is taken only from idle, so the port closes right after
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while a command is in progress");

  // the slice write-back always follows the head read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SLICE) |-> ($past(state_q) == S_EXEC || $past(state_q) == S_SLICE))
    else $error("slice write-back without a head read");

  // a full store never takes another admit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && item_q.op == OP_ADMIT && total_q >= ProcLimit) |-> !qcmd.push)
    else $error("admit pushed into a full store");

  // a result is never loaded over one that is still stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !emit)
    else $error("stalled result overwritten");

endmodule

`default_nettype wire

// File: verif/tb_multilevel_feedback_queue_scheduler_top.sv
// ----------------------------------------------------------------------------
// tb_multilevel_feedback_queue_scheduler_top
// Self-checking bench for the multilevel feedback queue scheduler. A queue
// of commands feeds a clocked driver; every accepted command runs through a
// scheduler predictor that keeps its own level FIFOs, live count and slice
// count, and appends the expected results. A clocked monitor compares each
// result transaction field by field. Phases walk the level count and the
// quantum through their extremes with random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_multilevel_feedback_queue_scheduler_top;
  import mlfq_pkg::*;

  localparam logic [1:0]  OpUnused    = 2'd3;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned LongHold    = 400;
  localparam longint      TimeLimit   = 64'd20_000_000;

  // idle modes for both channels
  localparam int unsigned IdleNone   = 0;
  localparam int unsigned IdleRandom = 1;
  localparam int unsigned IdleBursty = 2;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  sched_in_t   in_data_i   = '0;
  logic        out_stall_i = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  sched_out_t  out_data_o;
  logic [31:0] prdata;
  logic        pready;

  multilevel_feedback_queue_scheduler_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // commands waiting to be sent and results still owed by the block
  sched_in_t   pending_cmds[$];
  sched_out_t  owed_results[$];
  int unsigned cmds_queued   = 0;
  int unsigned cmds_accepted = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned tx_mode       = IdleNone;
  int unsigned rx_mode       = IdleNone;
  logic        rx_hold_req   = 1'b0;

  // scheduler state as the predictor sees it
  logic [7:0]  slot_mem [MaxLevelsDef*MaxProcsDef];
  int unsigned rd_ptr [MaxLevelsDef];
  int unsigned wr_ptr [MaxLevelsDef];
  int unsigned occupancy [MaxLevelsDef];
  int unsigned live_cnt    = 0;
  int unsigned slice_cnt   = 0;
  logic [3:0]  cfg_levels  = NumLevelsRst;
  logic [15:0] cfg_quantum = QuantumRst;

  initial begin
    for (int i = 0; i < MaxLevelsDef; i++) begin
      rd_ptr[i]    = 0;
      wr_ptr[i]    = 0;
      occupancy[i] = 0;
    end
  end

  function automatic int unsigned draw_idle(int unsigned mode);
    if (mode == IdleRandom) return $urandom_range(0, 17);
    if (mode == IdleBursty) return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
    return 0;
  endfunction

  function automatic void level_push(int unsigned q, logic [7:0] pid);
    slot_mem[q*MaxProcsDef + wr_ptr[q]] = pid;
    wr_ptr[q] = (wr_ptr[q] + 1) % MaxProcsDef;
    occupancy[q]++;
  endfunction

  function automatic logic [7:0] level_pop(int unsigned q);
    logic [7:0] pid;
    pid = slot_mem[q*MaxProcsDef + rd_ptr[q]];
    rd_ptr[q] = (rd_ptr[q] + 1) % MaxProcsDef;
    occupancy[q]--;
    return pid;
  endfunction

  function automatic void owe_result(status_e st, logic [7:0] pid, logic [3:0] lvl,
                                     logic lst);
    sched_out_t res;
    res.status      = st;
    res.proc_id_out = pid;
    res.level       = lvl;
    res.last        = lst;
    owed_results = {owed_results, res};
  endfunction

  // scheduler predictor: one accepted command, its results appended
  function automatic void schedule_cmd(sched_in_t cmd);
    int unsigned top;
    int unsigned q;
    int unsigned n;
    logic [7:0]  pid;
    logic [7:0]  moved_id [MaxProcsDef];
    int unsigned moved_lvl [MaxProcsDef];
    top = (cfg_levels == 0) ? 1 : ((cfg_levels > MaxLevelsDef) ? MaxLevelsDef : cfg_levels);
    case (cmd.op)
      OP_ADMIT: begin
        if (live_cnt >= MaxProcsDef) begin
          owe_result(ST_REJECTED, cmd.proc_id, 4'd0, 1'b1);
        end else begin
          level_push(top - 1, cmd.proc_id);
          live_cnt++;
          owe_result(ST_ADMITTED, cmd.proc_id, 4'(top), 1'b1);
        end
      end
      OP_SLICE: begin
        if (slice_cnt >= cfg_quantum) begin
          owe_result(ST_QUANTUM_OUT, 8'd0, 4'd0, 1'b1);
        end else begin
          // highest non-empty level within the levels in use
          q = top;
          while (q > 0 && occupancy[q-1] == 0) q--;
          if (q == 0) begin
            owe_result(ST_EMPTY, 8'd0, 4'd0, 1'b1);
          end else begin
            pid = level_pop(q - 1);
            slice_cnt++;
            if (cmd.final_instr) begin
              live_cnt--;
              owe_result(ST_ENDED, pid, 4'd0, 1'b1);
            end else if (!cmd.demote) begin
              level_push(q - 1, pid);
              owe_result(ST_STAYED, pid, 4'(q), 1'b1);
            end else if (q > 1) begin
              level_push(q - 2, pid);
              owe_result(ST_DEMOTED, pid, 4'(q - 1), 1'b1);
            end else begin
              // bottom level keeps the process
              level_push(0, pid);
              owe_result(ST_DEMOTED, pid, 4'd1, 1'b1);
            end
          end
        end
      end
      OP_RESTART: begin
        // gather every live process, highest level first, fifo order within
        n = 0;
        for (int lv = MaxLevelsDef; lv > 0; lv--) begin
          while (occupancy[lv-1] != 0) begin
            moved_id[n]  = level_pop(lv - 1);
            moved_lvl[n] = lv;
            n++;
          end
          rd_ptr[lv-1] = 0;
          wr_ptr[lv-1] = 0;
        end
        live_cnt  = n;
        slice_cnt = 0;
        for (int i = 0; i < n; i++) begin
          level_push(top - 1, moved_id[i]);
          if (moved_lvl[i] != top) owe_result(ST_BOOSTED, moved_id[i], 4'(top), 1'b0);
        end
        owe_result(ST_RESTART_DONE, 8'd0, 4'd0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // command driver
  int unsigned tx_gap = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      tx_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        schedule_cmd(in_data_i);
        cmds_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          in_data_i  <= pending_cmds.pop_front();
          in_valid_i <= 1'b1;
          tx_gap = draw_idle(tx_mode);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // result monitor with receiver stalls
  int unsigned rx_wait = 0;
  int unsigned rx_hold = 0;
  sched_out_t  want_res;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait = 0;
      rx_hold = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result transaction, actual status %0d id %0d level %0d last %0d",
                   $time, out_data_o.status, out_data_o.proc_id_out, out_data_o.level,
                   out_data_o.last);
          mismatch_cnt++;
        end else begin
          want_res = owed_results.pop_front();
          check_field("status", 8'(want_res.status), 8'(out_data_o.status));
          check_field("proc_id_out", want_res.proc_id_out, out_data_o.proc_id_out);
          check_field("level", 8'(want_res.level), 8'(out_data_o.level));
          check_field("last", 8'(want_res.last), 8'(out_data_o.last));
        end
        rx_wait = draw_idle(rx_mode);
      end
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_hold = LongHold;
      end
      if (rx_hold != 0) begin
        rx_hold--;
        out_stall_i <= 1'b1;
      end else if (rx_wait != 0) begin
        rx_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic add_cmd(logic [1:0] op, logic [7:0] pid, logic dem, logic fin);
    sched_in_t cmd;
    cmd.op          = op;
    cmd.proc_id     = pid;
    cmd.demote      = dem;
    cmd.final_instr = fin;
    pending_cmds = {pending_cmds, cmd};
    cmds_queued++;
  endtask

  // random commands, unused opcodes sprinkled in without counting
  task automatic add_random_cmds(int unsigned count, int unsigned admit_pct);
    int unsigned done;
    int unsigned pick;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick >= 97) begin
        add_cmd(OpUnused, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
      end else begin
        if (pick < admit_pct)
          add_cmd(OP_ADMIT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        else if (pick < 87)
          add_cmd(OP_SLICE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 3) == 0));
        else
          add_cmd(OP_RESTART, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        done++;
      end
    end
  endtask

  // every command accepted, every result seen, block settled
  task automatic wait_idle();
    while (cmds_accepted != cmds_queued) @(posedge clk_i);
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // register write followed by a read back
  task automatic reg_write(reg_idx_e idx, logic [15:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_NUM_LEVELS) cfg_levels = value[3:0];
    else cfg_quantum = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((idx == REG_NUM_LEVELS) ? (prdata[3:0] !== value[3:0]) : (prdata[15:0] !== value)) begin
      $display("%0t: register %0d read back, expected %0d, actual %0d", $time, idx, value,
               prdata);
      mismatch_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // stimulus phases
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty slice, empty restart, unused op, full walk to the bottom
    add_cmd(OP_SLICE, 8'h00, 1'b0, 1'b0);
    add_cmd(OP_RESTART, 8'h00, 1'b0, 1'b0);
    add_cmd(OpUnused, 8'hff, 1'b1, 1'b1);
    add_cmd(OP_ADMIT, 8'h00, 1'b0, 1'b0);
    add_cmd(OP_ADMIT, 8'hff, 1'b1, 1'b1);
    add_cmd(OP_ADMIT, 8'ha5, 1'b0, 1'b0);
    add_cmd(OP_SLICE, 8'h00, 1'b0, 1'b0);
    add_cmd(OP_SLICE, 8'h00, 1'b1, 1'b0);
    add_cmd(OP_SLICE, 8'h00, 1'b1, 1'b1);
    add_cmd(OP_SLICE, 8'h00, 1'b1, 1'b0);
    add_cmd(OP_SLICE, 8'h00, 1'b1, 1'b0);
    add_cmd(OP_SLICE, 8'h00, 1'b1, 1'b0);
    add_cmd(OP_SLICE, 8'h00, 1'b1, 1'b0);
    add_cmd(OP_SLICE, 8'h00, 1'b0, 1'b0);
    add_cmd(OP_SLICE, 8'h00, 1'b0, 1'b0);
    add_cmd(OP_RESTART, 8'h00, 1'b0, 1'b0);
    add_cmd(OP_ADMIT, 8'h5a, 1'b0, 1'b0);
    add_cmd(OP_SLICE, 8'h00, 1'b0, 1'b1);
    add_cmd(OP_SLICE, 8'h00, 1'b0, 1'b1);
    add_cmd(OP_SLICE, 8'h00, 1'b0, 1'b1);
    add_cmd(OP_SLICE, 8'h00, 1'b0, 1'b0);
    wait_idle();

    // all levels, widest quantum: fill past the store size, then shuffle
    tx_mode = IdleRandom;
    rx_mode = IdleRandom;
    reg_write(REG_NUM_LEVELS, 16'd8);
    reg_write(REG_QUANTUM, 16'd65535);
    for (int i = 0; i < 34; i++) add_cmd(OP_ADMIT, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
    add_random_cmds(5, 10);
    add_cmd(OP_RESTART, 8'h00, 1'b0, 1'b0);
    wait_idle();

    // shrunk levels, one slice per quantum, receiver held off while sender floods
    tx_mode = IdleNone;
    rx_mode = IdleBursty;
    reg_write(REG_NUM_LEVELS, 16'd2);
    reg_write(REG_QUANTUM, 16'd1);
    rx_hold_req = 1'b1;
    add_random_cmds(15, 30);
    wait_idle();

    // zero levels taken as one, zero quantum
    tx_mode = IdleBursty;
    rx_mode = IdleRandom;
    reg_write(REG_NUM_LEVELS, 16'd0);
    reg_write(REG_QUANTUM, 16'd0);
    add_random_cmds(8, 30);
    wait_idle();

    // level count above the maximum
    tx_mode = IdleRandom;
    rx_mode = IdleNone;
    reg_write(REG_NUM_LEVELS, 16'd15);
    reg_write(REG_QUANTUM, 16'd5);
    add_random_cmds(15, 35);
    wait_idle();

    // single level
    tx_mode = IdleNone;
    rx_mode = IdleBursty;
    reg_write(REG_NUM_LEVELS, 16'd1);
    reg_write(REG_QUANTUM, 16'd3);
    add_random_cmds(10, 35);
    wait_idle();

    // middle setting
    tx_mode = IdleBursty;
    rx_mode = IdleBursty;
    reg_write(REG_NUM_LEVELS, 16'd5);
    reg_write(REG_QUANTUM, 16'd200);
    add_random_cmds(12, 35);
    wait_idle();

    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TimeLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
